// ===== hw/rtl/mmf_pkg.sv =====
// Shared types and constants for the 3x3 median/mode filter.
// No dependencies; imported by every module of the block.
package mmf_pkg;

  localparam int ISZ_W = 11;  // image_size register width
  localparam int CNT_W = 21;  // output pixel counter width
  localparam int TOT_W = 22;  // width of size*size
  localparam int WIN_N = 9;   // window taps
  localparam int MED_IDX = 4; // rank of the median among the taps
  localparam int TAP_CW = 4;  // width of an equal-tap count

  typedef enum logic [0:0] {
    CFG_IMAGE_SIZE  = 1'b0,
    CFG_FILTER_MODE = 1'b1
  } cfg_idx_t;

  typedef enum logic [0:0] {
    OP_PIXEL = 1'b0,
    OP_DRAIN = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    MODE_MEDIAN = 1'b0,
    MODE_MODE   = 1'b1
  } fmode_t;

  // request control from the input counters to the line stage
  typedef struct packed {
    logic valid;
    logic drain;
    logic first;  // column 0
    logic last;   // last column
    logic row0;   // top row of the image
  } s0_ctl_t;

  // up to two results per request, with their flags
  typedef struct packed {
    logic va;
    logic vb;
    logic lir_a;
    logic lir_b;
    logic ie_a;
    logic ie_b;
  } emit_t;

  typedef struct packed {
    logic v;
    logic lir;
    logic ie;
  } res_tag_t;

endpackage

// ===== hw/rtl/mmf_line.sv =====
// Line stores, window register and output pixel counter.
// Depends on mmf_pkg.
module mmf_line import mmf_pkg::*; #(
  parameter int DEPTH = 1024,
  parameter int PW    = 8,
  parameter int AW    = 10
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  s0_ctl_t                   s0_ctl,
  input  logic [AW-1:0]             s0_addr,
  input  logic [PW-1:0]             s0_px,
  input  logic [TOT_W-1:0]          total,
  input  logic                      cnt_clr,
  output emit_t                     em,
  output logic [WIN_N-1:0][PW-1:0]  win_a,
  output logic [WIN_N-1:0][PW-1:0]  win_b
);

  logic [PW-1:0] upper_mem [DEPTH];
  logic [PW-1:0] middle_mem [DEPTH];

  logic [PW-1:0]   up_q_r, mid_q_r, fwd_r;
  s0_ctl_t         s1_ctl_r;
  logic [AW-1:0]   s1_addr_r;
  logic [PW-1:0]   s1_px_r;
  logic            collide_r, collide_nxt;
  logic [PW-1:0]   t, m, b, up_wdata;
  logic [PW-1:0]   win_r [WIN_N];
  logic [PW-1:0]   w1 [WIN_N];
  logic [PW-1:0]   w2 [WIN_N];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, cnt_mid;
  logic            e1, e2;
  emit_t           em_r;
  logic [WIN_N-1:0][PW-1:0] win_a_r, win_b_r;

  // upper write of the previous request lands in the same cycle as this read
  assign collide_nxt = s1_ctl_r.valid && !s1_ctl_r.drain && (s1_addr_r == s0_addr);

  always_ff @(posedge clk) begin
    up_q_r  <= upper_mem[s0_addr];
    mid_q_r <= middle_mem[s0_addr];
    if (s0_ctl.valid && !s0_ctl.drain) begin
      middle_mem[s0_addr] <= s0_px;
    end
    if (s1_ctl_r.valid && !s1_ctl_r.drain) begin
      upper_mem[s1_addr_r] <= up_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_ctl_r <= '0;
    end else begin
      s1_ctl_r <= s0_ctl;
    end
    s1_addr_r <= s0_addr;
    s1_px_r   <= s0_px;
    collide_r <= collide_nxt;
    if (s1_ctl_r.valid && !s1_ctl_r.drain) begin
      fwd_r <= up_wdata;
    end
  end

  assign t        = collide_r ? fwd_r : up_q_r;
  assign m        = mid_q_r;
  assign b        = s1_ctl_r.drain ? m : s1_px_r;
  assign up_wdata = s1_ctl_r.row0 ? s1_px_r : m;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      if (s1_ctl_r.first) begin
        w1[3*k]   = (k == 0) ? t : ((k == 1) ? m : b);
        w1[3*k+1] = (k == 0) ? t : ((k == 1) ? m : b);
        w1[3*k+2] = (k == 0) ? t : ((k == 1) ? m : b);
      end else begin
        w1[3*k]   = win_r[3*k+1];
        w1[3*k+1] = win_r[3*k+2];
        w1[3*k+2] = (k == 0) ? t : ((k == 1) ? m : b);
      end
    end
    // replicate the right border for the last column
    for (int k = 0; k < 3; k++) begin
      if (s1_ctl_r.first) begin
        w2[3*k]   = w1[3*k];
        w2[3*k+1] = w1[3*k+1];
        w2[3*k+2] = w1[3*k+2];
      end else begin
        w2[3*k]   = w1[3*k+1];
        w2[3*k+1] = w1[3*k+2];
        w2[3*k+2] = w1[3*k+2];
      end
    end
  end

  assign e1      = !s1_ctl_r.first && !s1_ctl_r.row0;
  assign e2      = s1_ctl_r.last && !s1_ctl_r.row0;
  assign cnt_mid = e1 ? cnt_r + 1'b1 : cnt_r;

  always_comb begin
    cnt_nxt = cnt_r;
    if (s1_ctl_r.valid) begin
      cnt_nxt = e2 ? cnt_mid + 1'b1 : cnt_mid;
      if (s1_ctl_r.drain && s1_ctl_r.last) begin
        cnt_nxt = '0;
      end
    end
    if (cnt_clr) begin
      cnt_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      em_r.va <= 1'b0;
      em_r.vb <= 1'b0;
      for (int i = 0; i < WIN_N; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      cnt_r   <= cnt_nxt;
      em_r.va <= s1_ctl_r.valid && e1;
      em_r.vb <= s1_ctl_r.valid && e2;
      if (s1_ctl_r.valid) begin
        for (int i = 0; i < WIN_N; i++) begin
          win_r[i] <= (s1_ctl_r.last && !s1_ctl_r.first) ? w2[i] : w1[i];
        end
      end
    end
    em_r.lir_a <= e1 && !e2;
    em_r.lir_b <= e2;
    em_r.ie_a  <= ({1'b0, cnt_r} == total);
    em_r.ie_b  <= ({1'b0, cnt_mid} == total);
    for (int i = 0; i < WIN_N; i++) begin
      win_a_r[i] <= w1[i];
      win_b_r[i] <= w2[i];
    end
  end

  assign em    = em_r;
  assign win_a = win_a_r;
  assign win_b = win_b_r;

  a_two_need_last: assert property (@(posedge clk) disable iff (!rst_n)
    em_r.vb |-> em_r.lir_b && !em_r.lir_a) else $error("second result not marked last");
  a_first_no_a: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.valid && s1_ctl_r.first) |=> !em_r.va) else $error("result at column zero");
  a_row0_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_ctl_r.valid && s1_ctl_r.row0) |=> !em_r.va && !em_r.vb)
    else $error("result during top row");

endmodule

// ===== hw/rtl/mmf_filt.sv =====
// Two-stage window filter: median by row sort, mode by tap counting.
// Depends on mmf_pkg.
module mmf_filt import mmf_pkg::*; #(
  parameter int PW = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  fmode_t                   mode,
  input  res_tag_t                 tag_in,
  input  logic [WIN_N-1:0][PW-1:0] win,
  output res_tag_t                 tag_out,
  output logic [PW-1:0]            value
);

  function automatic logic [PW-1:0] max2(input logic [PW-1:0] x, input logic [PW-1:0] y);
    max2 = (x > y) ? x : y;
  endfunction

  function automatic logic [PW-1:0] min2(input logic [PW-1:0] x, input logic [PW-1:0] y);
    min2 = (x < y) ? x : y;
  endfunction

  function automatic logic [PW-1:0] med3(input logic [PW-1:0] x, input logic [PW-1:0] y,
                                         input logic [PW-1:0] z);
    med3 = max2(min2(x, y), min2(max2(x, y), z));
  endfunction

  res_tag_t      sa_tag_r, sb_tag_r;
  logic [PW-1:0] sa_lo_r [3];
  logic [PW-1:0] sa_md_r [3];
  logic [PW-1:0] sa_hi_r [3];
  logic [PW-1:0] sa_val_r [WIN_N];
  logic [TAP_CW-1:0] sa_cnt_r [WIN_N];
  logic [TAP_CW-1:0] cnt_c [WIN_N];
  logic [PW-1:0] med_c, pick_c, sb_val_r;
  logic [TAP_CW-1:0] best_c;

  always_comb begin
    for (int i = 0; i < WIN_N; i++) begin
      cnt_c[i] = '0;
      for (int j = 0; j < WIN_N; j++) begin
        cnt_c[i] = cnt_c[i] + TAP_CW'(win[i] == win[j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sa_tag_r <= '0;
      sb_tag_r <= '0;
    end else begin
      sa_tag_r <= tag_in;
      sb_tag_r <= sa_tag_r;
    end
    for (int r = 0; r < 3; r++) begin
      sa_lo_r[r] <= min2(win[3*r], min2(win[3*r+1], win[3*r+2]));
      sa_md_r[r] <= med3(win[3*r], win[3*r+1], win[3*r+2]);
      sa_hi_r[r] <= max2(win[3*r], max2(win[3*r+1], win[3*r+2]));
    end
    for (int i = 0; i < WIN_N; i++) begin
      sa_val_r[i] <= win[i];
      sa_cnt_r[i] <= cnt_c[i];
    end
    sb_val_r <= (mode == MODE_MODE) ? pick_c : med_c;
  end

  // median of nine: max of row minima, median of row medians, min of row maxima
  assign med_c = med3(max2(sa_lo_r[0], max2(sa_lo_r[1], sa_lo_r[2])),
                      med3(sa_md_r[0], sa_md_r[1], sa_md_r[2]),
                      min2(sa_hi_r[0], min2(sa_hi_r[1], sa_hi_r[2])));

  // first tap with the highest count wins
  always_comb begin
    best_c = '0;
    pick_c = '0;
    for (int i = 0; i < WIN_N; i++) begin
      if (sa_cnt_r[i] > best_c) begin
        best_c = sa_cnt_r[i];
        pick_c = sa_val_r[i];
      end
    end
  end

  assign tag_out = sb_tag_r;
  assign value   = sb_val_r;

endmodule

// ===== hw/rtl/mmf_fifo.sv =====
// Result queue with two write ports, one read port.
// Depends on mmf_pkg.
module mmf_fifo import mmf_pkg::*; #(
  parameter int PW    = 8,
  parameter int DEPTH = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push_a,
  input  logic [PW+1:0]              data_a,
  input  logic                       push_b,
  input  logic [PW+1:0]              data_b,
  input  logic                       pop,
  output logic [PW+1:0]              head,
  output logic                       not_empty,
  output logic [$clog2(DEPTH+1)-1:0] count
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);

  logic [PW+1:0]    mem [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r, wp_nxt, rp_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;

  always_comb begin
    wp_nxt  = wp_r + PTR_W'(push_a) + PTR_W'(push_b);
    rp_nxt  = rp_r + PTR_W'(pop);
    cnt_nxt = cnt_r + CW'(push_a) + CW'(push_b) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_a) begin
      mem[wp_r] <= data_a;
    end
    if (push_b) begin
      mem[push_a ? wp_r + 1'b1 : wp_r] <= data_b;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  assign head      = mem[rp_r];
  assign not_empty = (cnt_r != '0);
  assign count     = cnt_r;

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(DEPTH)) else $error("result queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> cnt_r != '0) else $error("result queue underflow");

endmodule

// ===== hw/rtl/median_mode_3x3_filter.sv =====
// 3x3 median / mode filter for a square grey image in raster order.
// Depends on mmf_pkg, mmf_line, mmf_filt, mmf_fifo.
//
// Usage:
//   Input channel (in_valid/in_stall, in_op, in_pixel): one request per pixel,
//   raster order, then image_size drain requests (in_op = drain) to flush the
//   last row. Drains before the image is complete, and pixels while draining,
//   are taken and dropped.
//   Output channel (out_valid/out_stall): results in raster order, lagging one
//   row. A request at the last column can give two results; last_in_run marks
//   the final result of a request, image_end the bottom-right pixel.
//   Config port: cfg_we/cfg_index/cfg_data, write only while idle. Writing
//   image_size restarts the image; the line stores keep their contents.
// Timing:
//   One request per clock while in_stall is low. A result passes the line-store
//   read, window, two filter stages and queue write before reaching the output.
//   Results go to a 16-entry queue; in_stall rises once more than 6 entries
//   wait, which covers everything still inside the four-stage pipeline.
//   A stalled receiver only fills the queue; the pipeline never stops.
// Reset: counters, window and queue clear; image_size 512, median mode.
module median_mode_3x3_filter import mmf_pkg::*; #(
  parameter int MAX_SIZE   = 1024,
  parameter int PIXEL_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic                  in_op,
  input  logic [PIXEL_BITS-1:0] in_pixel,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [PIXEL_BITS-1:0] out_value,
  output logic                  out_last_in_run,
  output logic                  out_image_end,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [ISZ_W-1:0]      cfg_data
);

  localparam int AW       = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
  localparam int QDEPTH   = 16;
  localparam int QCW      = $clog2(QDEPTH + 1);
  localparam int STALL_TH = QDEPTH - 10;  // 4 stages x 2 results + next request

  logic [ISZ_W-1:0] size_r, eff;
  fmode_t           mode_r;
  logic [TOT_W-1:0] total_r;
  logic [ISZ_W-1:0] row_r, col_r, row_nxt, col_nxt;
  logic             accept, drain, at_end_row, act, size_wr;
  s0_ctl_t          s0_ctl;
  emit_t            em;
  logic [WIN_N-1:0][PIXEL_BITS-1:0] win_a, win_b;
  res_tag_t         tag_a, tag_b, ftag_a, ftag_b;
  logic [PIXEL_BITS-1:0] fval_a, fval_b;
  logic [PIXEL_BITS+1:0] head;
  logic [QCW-1:0]   qcount;

  // size 0 acts as 1, above MAX_SIZE acts as MAX_SIZE
  always_comb begin
    eff = size_r;
    if (size_r == '0) begin
      eff = ISZ_W'(1);
    end else if ({21'd0, size_r} > MAX_SIZE) begin
      eff = ISZ_W'(MAX_SIZE);
    end
  end

  assign size_wr = cfg_we && (cfg_idx_t'(cfg_index) == CFG_IMAGE_SIZE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= ISZ_W'(512);
      mode_r <= MODE_MEDIAN;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_IMAGE_SIZE:  size_r <= cfg_data;
        CFG_FILTER_MODE: mode_r <= fmode_t'(cfg_data[0]);
        default:         size_r <= size_r;
      endcase
    end
    total_r <= TOT_W'(eff) * TOT_W'(eff) - 1'b1;
  end

  // input position counters
  assign accept     = in_valid && !in_stall;
  assign drain      = (op_t'(in_op) == OP_DRAIN);
  assign at_end_row = (row_r == eff);
  assign act        = accept && (drain == at_end_row);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r;
    if (act) begin
      if (col_r == eff - 1'b1) begin
        col_nxt = '0;
        row_nxt = at_end_row ? '0 : row_r + 1'b1;
      end else begin
        col_nxt = col_r + 1'b1;
      end
    end
    if (size_wr) begin
      row_nxt = '0;
      col_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      col_r <= '0;
    end else begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  always_comb begin
    s0_ctl.valid = act;
    s0_ctl.drain = drain;
    s0_ctl.first = (col_r == '0);
    s0_ctl.last  = (col_r == eff - 1'b1);
    s0_ctl.row0  = (row_r == '0);
  end

  mmf_line #(
    .DEPTH (MAX_SIZE),
    .PW    (PIXEL_BITS),
    .AW    (AW)
  ) u_line (
    .clk     (clk),
    .rst_n   (rst_n),
    .s0_ctl  (s0_ctl),
    .s0_addr (AW'(col_r)),
    .s0_px   (in_pixel),
    .total   (total_r),
    .cnt_clr (size_wr),
    .em      (em),
    .win_a   (win_a),
    .win_b   (win_b)
  );

  assign tag_a = '{v: em.va, lir: em.lir_a, ie: em.ie_a};
  assign tag_b = '{v: em.vb, lir: em.lir_b, ie: em.ie_b};

  mmf_filt #(.PW(PIXEL_BITS)) u_filt_a (
    .clk (clk), .rst_n (rst_n), .mode (mode_r),
    .tag_in (tag_a), .win (win_a), .tag_out (ftag_a), .value (fval_a)
  );

  mmf_filt #(.PW(PIXEL_BITS)) u_filt_b (
    .clk (clk), .rst_n (rst_n), .mode (mode_r),
    .tag_in (tag_b), .win (win_b), .tag_out (ftag_b), .value (fval_b)
  );

  mmf_fifo #(.PW(PIXEL_BITS), .DEPTH(QDEPTH)) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_a    (ftag_a.v),
    .data_a    ({fval_a, ftag_a.lir, ftag_a.ie}),
    .push_b    (ftag_b.v),
    .data_b    ({fval_b, ftag_b.lir, ftag_b.ie}),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .not_empty (out_valid),
    .count     (qcount)
  );

  assign in_stall        = (qcount > QCW'(STALL_TH));
  assign out_value       = head[PIXEL_BITS+1:2];
  assign out_last_in_run = head[1];
  assign out_image_end   = head[0];

  a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    col_r < eff) else $error("column counter out of range");
  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= eff) else $error("row counter out of range");
  a_size_restart: assert property (@(posedge clk) disable iff (!rst_n)
    size_wr |=> row_r == '0 && col_r == '0) else $error("size write did not restart");

endmodule

// ===== dv/tb_top.sv =====
// Self-checking bench for the 3x3 median/mode filter: random and directed images,
// predicted in-bench and compared result by result. Depends on mmf_pkg and the RTL.
module tb_top;
  import mmf_pkg::*;

  localparam int MAXS = 1024;

  typedef struct packed {
    op_t op;
    logic [7:0] pixel;
  } pix_req_t;

  typedef struct packed {
    logic [7:0] value;
    logic lir;
    logic ie;
  } filt_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_op = 1'b0;
  logic [7:0] in_pixel = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] out_value;
  logic out_last_in_run;
  logic out_image_end;
  logic cfg_we = 1'b0;
  logic cfg_index = 1'b0;
  logic [ISZ_W-1:0] cfg_data = '0;

  median_mode_3x3_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_op(in_op), .in_pixel(in_pixel),
    .out_valid(out_valid), .out_stall(out_stall), .out_value(out_value),
    .out_last_in_run(out_last_in_run), .out_image_end(out_image_end),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // ---------------- predictor state ----------------
  logic [10:0] size_reg;
  fmode_t mode_reg;
  logic [7:0] up_line [MAXS];
  logic [7:0] mid_line [MAXS];
  logic [7:0] win [9];
  int unsigned row_cnt, col_cnt, res_cnt;

  pix_req_t pending_reqs[$];
  filt_res_t expected_res[$];
  int errors = 0;
  longint cycles = 0;

  // knobs for the idling phases and the long hold-off
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  logic hold_on = 1'b0;

  function automatic int unsigned eff_size();
    if (size_reg == 0) return 1;
    if (size_reg > MAXS) return MAXS;
    return size_reg;
  endfunction

  function automatic logic [7:0] win_median();
    logic [7:0] s [9];
    logic [7:0] tmp;
    for (int i = 0; i < 9; i++) s[i] = win[i];
    for (int i = 0; i < 9; i++)
      for (int j = 0; j < 8 - i; j++)
        if (s[j] > s[j+1]) begin
          tmp = s[j]; s[j] = s[j+1]; s[j+1] = tmp;
        end
    return s[4];
  endfunction

  function automatic logic [7:0] win_mode();
    int best = 0;
    int cnt;
    logic [7:0] pick = '0;
    for (int i = 0; i < 9; i++) begin
      cnt = 0;
      for (int j = 0; j < 9; j++) if (win[j] == win[i]) cnt++;
      if (cnt > best) begin
        best = cnt; pick = win[i];
      end
    end
    return pick;
  endfunction

  function automatic void shift_in(logic [7:0] t, logic [7:0] m, logic [7:0] b);
    for (int k = 0; k < 3; k++) begin
      win[3*k] = win[3*k+1];
      win[3*k+1] = win[3*k+2];
    end
    win[2] = t; win[5] = m; win[8] = b;
  endfunction

  function automatic void push_result(int unsigned n);
    filt_res_t r;
    r.value = (mode_reg == MODE_MODE) ? win_mode() : win_median();
    r.lir = 1'b0;
    r.ie = (res_cnt == n * n - 1);
    res_cnt = (res_cnt + 1) & 21'h1FFFFF;
    expected_res.push_back(r);
  endfunction

  function automatic void predict_config(cfg_idx_t idx, logic [10:0] val);
    if (idx == CFG_IMAGE_SIZE) begin
      size_reg = val; row_cnt = 0; col_cnt = 0; res_cnt = 0;
    end else begin
      mode_reg = fmode_t'(val[0]);
    end
  endfunction

  // expected results of one accepted request
  function automatic void predict_filter(pix_req_t rq);
    int unsigned n = eff_size();
    int unsigned c;
    int n_queued = expected_res.size();
    logic drain = (rq.op == OP_DRAIN);
    logic [7:0] t, m, b;
    if (col_cnt >= n) col_cnt = 0;
    if (row_cnt > n) row_cnt = 0;
    if (drain != (row_cnt == n)) return;  // early drain / pixel while draining
    c = col_cnt;
    t = up_line[c]; m = mid_line[c];
    b = drain ? m : rq.pixel;
    if (!drain) begin
      up_line[c] = (row_cnt == 0) ? rq.pixel : m;
      mid_line[c] = rq.pixel;
    end
    if (c == 0) begin
      for (int k = 0; k < 3; k++) begin
        win[k] = t; win[3+k] = m; win[6+k] = b;
      end
    end else begin
      shift_in(t, m, b);
      if (row_cnt >= 1) push_result(n);
    end
    if (c == n - 1) begin
      if (c >= 1) shift_in(win[2], win[5], win[8]);
      if (row_cnt >= 1) push_result(n);
    end
    if (expected_res.size() > n_queued) expected_res[$].lir = 1'b1;
    col_cnt++;
    if (col_cnt >= n) begin
      col_cnt = 0;
      if (row_cnt == n) begin
        row_cnt = 0; res_cnt = 0;
      end else begin
        row_cnt++;
      end
    end
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want, cycles);
    errors++;
  endtask

  // ---------------- driver ----------------
  // A request leaves the queue when it is put on the interface; valid stays put while stalled.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) predict_filter(pix_req_t'{op_t'(in_op), in_pixel});
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_op <= pending_reqs[0].op;
          in_pixel <= pending_reqs[0].pixel;
          void'(pending_reqs.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------- monitor ----------------
  always @(posedge clk) begin
    filt_res_t want;
    cycles++;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_res.size() == 0) begin
        report_mismatch("unexpected result, value", out_value, -1);
      end else begin
        want = expected_res.pop_front();
        if (out_value !== want.value) report_mismatch("value", out_value, want.value);
        if (out_last_in_run !== want.lir)
          report_mismatch("last_in_run", out_last_in_run, want.lir);
        if (out_image_end !== want.ie)
          report_mismatch("image_end", out_image_end, want.ie);
      end
    end
    // receiver stall: a long hold-off wins over random idling
    if (hold_on) begin
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------- stimulus ----------------
  task automatic add_req(op_t op, logic [7:0] px);
    pending_reqs.push_back(pix_req_t'{op, px});
  endtask

  // one full image plus its drains; pattern 0 random, 1 few levels, 2 extremes
  task automatic add_image(int unsigned n, int pattern);
    for (int i = 0; i < n * n; i++) begin
      case (pattern)
        0: add_req(OP_PIXEL, 8'($urandom));
        1: add_req(OP_PIXEL, 8'($urandom_range(3)));
        default: add_req(OP_PIXEL, $urandom_range(1) ? 8'hFF : 8'h00);
      endcase
    end
    for (int i = 0; i < n; i++) add_req(OP_DRAIN, 8'($urandom));
  endtask

  // wait until everything is sent and received, then let the pipeline empty
  task automatic drain_all();
    while (pending_reqs.size() > 0 || in_valid || expected_res.size() > 0)
      @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_t idx, logic [10:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(posedge clk);
    predict_config(idx, val);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  int unsigned sz;

  initial begin
    size_reg = 11'd512; mode_reg = MODE_MEDIAN;
    row_cnt = 0; col_cnt = 0; res_cnt = 0;
    for (int i = 0; i < 9; i++) win[i] = '0;
    for (int i = 0; i < MAXS; i++) begin
      up_line[i] = '0; mid_line[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: size 1, size 0 (acts as 1), tiny images in both modes,
    // early drains and stray pixels while draining
    write_cfg(CFG_IMAGE_SIZE, 11'd1);
    write_cfg(CFG_FILTER_MODE, MODE_MEDIAN);
    add_req(OP_DRAIN, 8'h00);  // early drain, dropped
    add_req(OP_PIXEL, 8'hFF);
    add_req(OP_PIXEL, 8'h12);  // pixel while draining, dropped
    add_req(OP_DRAIN, 8'hFF);
    drain_all();
    write_cfg(CFG_IMAGE_SIZE, 11'd0);
    add_image(1, 0);
    drain_all();
    write_cfg(CFG_IMAGE_SIZE, 11'd2);
    write_cfg(CFG_FILTER_MODE, MODE_MODE);
    add_req(OP_PIXEL, 8'h00); add_req(OP_PIXEL, 8'hFF);
    add_req(OP_DRAIN, 8'h55);  // early
    add_req(OP_PIXEL, 8'hFF); add_req(OP_PIXEL, 8'h00);
    add_req(OP_DRAIN, 8'h00); add_req(OP_PIXEL, 8'h77); add_req(OP_DRAIN, 8'h00);
    drain_all();
    write_cfg(CFG_IMAGE_SIZE, 11'd3);
    add_image(3, 1);
    drain_all();

    // random phase 1: sender rarely idles, receiver mostly stalls
    send_idle_pct = 7; recv_idle_pct = 74;
    for (int k = 0; k < 8; k++) begin
      sz = $urandom_range(2, 9);
      write_cfg(CFG_IMAGE_SIZE, 11'(sz));
      write_cfg(CFG_FILTER_MODE, fmode_t'($urandom_range(1)));
      add_image(sz, $urandom_range(2));
      if ($urandom_range(3) == 0) add_req(OP_DRAIN, 8'($urandom));
      drain_all();
    end

    // long receiver hold-off while the sender keeps going: in_stall must rise
    write_cfg(CFG_IMAGE_SIZE, 11'd8);
    add_image(8, 0);
    fork
      begin
        hold_on = 1'b1;
        repeat (200) @(posedge clk);
        hold_on = 1'b0;
      end
    join_none
    drain_all();

    // random phase 2: roles swapped
    send_idle_pct = 74; recv_idle_pct = 7;
    for (int k = 0; k < 8; k++) begin
      sz = $urandom_range(2, 9);
      write_cfg(CFG_IMAGE_SIZE, 11'(sz));
      write_cfg(CFG_FILTER_MODE, fmode_t'($urandom_range(1)));
      add_image(sz, $urandom_range(2));
      drain_all();
    end

    // phase 3: no idling; one wide image touches the large-size path,
    // then size above the maximum (clamped) with a restart mid-image
    send_idle_pct = 0; recv_idle_pct = 0;
    write_cfg(CFG_IMAGE_SIZE, 11'd26);
    add_image(26, 0);
    drain_all();
    write_cfg(CFG_IMAGE_SIZE, 11'd2047);
    for (int i = 0; i < 40; i++) add_req(OP_PIXEL, 8'($urandom));
    drain_all();
    write_cfg(CFG_IMAGE_SIZE, 11'd1024);
    for (int i = 0; i < 10; i++) add_req(OP_PIXEL, 8'($urandom));
    drain_all();
    for (int k = 0; k < 5; k++) begin
      sz = $urandom_range(2, 6);
      write_cfg(CFG_IMAGE_SIZE, 11'(sz));
      write_cfg(CFG_FILTER_MODE, fmode_t'(k & 1));
      add_image(sz, $urandom_range(2));
      drain_all();
    end

    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/mmf_pkg.sv
hw/rtl/mmf_line.sv
hw/rtl/mmf_filt.sv
hw/rtl/mmf_fifo.sv
hw/rtl/median_mode_3x3_filter.sv
dv/tb_top.sv
